>>> sv/pmt_pkg.sv
// ----------------------------------------------------------------------------
// pmt_pkg: shared types and constants of the PMT section parser
// Result codes, header byte positions and the result word layout.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int PMT_MAX_STREAMS = 16;

  localparam logic [7:0] PMT_TABLE_ID = 8'h02;

  // result kinds
  localparam logic [1:0] KIND_HEADER    = 2'd0;
  localparam logic [1:0] KIND_ENTRY     = 2'd1;
  localparam logic [1:0] KIND_BAD_TID   = 2'd2;
  localparam logic [1:0] KIND_TOO_MANY  = 2'd3;

  // header byte positions (table id is position 0)
  localparam logic [3:0] HB_SYNTAX_LEN_HI = 4'd1;
  localparam logic [3:0] HB_LEN_LO        = 4'd2;
  localparam logic [3:0] HB_PROG_HI       = 4'd3;
  localparam logic [3:0] HB_PROG_LO       = 4'd4;
  localparam logic [3:0] HB_VERSION       = 4'd5;
  localparam logic [3:0] HB_SEC_NUM       = 4'd6;
  localparam logic [3:0] HB_LAST_SEC      = 4'd7;
  localparam logic [3:0] HB_PCR_HI        = 4'd8;
  localparam logic [3:0] HB_PCR_LO        = 4'd9;
  localparam logic [3:0] HB_PIL_HI        = 4'd10;

  // stream entry byte positions
  localparam logic [2:0] EB_STYPE  = 3'd0;
  localparam logic [2:0] EB_PID_HI = 3'd1;
  localparam logic [2:0] EB_PID_LO = 3'd2;
  localparam logic [2:0] EB_ES_HI  = 3'd3;

  // fixed part of the byte count: 12 header bytes plus 4 CRC bytes minus 3
  localparam logic [13:0] PMT_HDR_BASE  = 14'd13;
  localparam logic [13:0] PMT_ENTRY_LEN = 14'd5;

  typedef struct packed {
    logic [7:0] section_byte;
    logic       section_start;
  } pmt_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic        section_syntax;
    logic [11:0] sect_len;
    logic [4:0]  version;
    logic        current_next;
    logic [7:0]  sect_num;
    logic [7:0]  last_sect_num;
    logic [15:0] prog_num;
    logic [7:0]  es_type;
    logic [12:0] pid;
    logic [11:0] info_length;
  } pmt_result_t;

endpackage

>>> sv/pmt_if.sv
// ----------------------------------------------------------------------------
// pmt_in_if / pmt_out_if: section byte and result channels
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface pmt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] section_byte;
  logic       section_start;

  modport source (output valid, output section_byte, output section_start, input ready);
  modport sink   (input valid, input section_byte, input section_start, output ready);
endinterface

interface pmt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic        last;
  logic        section_syntax;
  logic [11:0] sect_len;
  logic [4:0]  version;
  logic        current_next;
  logic [7:0]  sect_num;
  logic [7:0]  last_sect_num;
  logic [15:0] prog_num;
  logic [7:0]  es_type;
  logic [12:0] pid;
  logic [11:0] info_length;

  modport source (
    output valid, output kind, output last, output section_syntax, output sect_len,
    output version, output current_next, output sect_num,
    output last_sect_num, output prog_num, output es_type, output pid,
    output info_length, input ready
  );
  modport sink (
    input valid, input kind, input last, input section_syntax, input sect_len,
    input version, input current_next, input sect_num,
    input last_sect_num, input prog_num, input es_type, input pid,
    input info_length, output ready
  );
endinterface

>>> sv/pmt_section_parser.sv
// ----------------------------------------------------------------------------
// pmt_section_parser: streaming PMT section parser
// Unpacks program map table sections into header and stream entry results.
// ----------------------------------------------------------------------------
// Feed one section byte per word, with section_start high on the table id.
// The block takes one byte every cycle while the result register is free:
// a byte passes from the input register through the parse state machine
// into the result register, whose output is presented on out_ch.
// A header result comes on the last of the 12 header bytes and an entry
// result on the fifth byte of each stream entry; other bytes give none.
// A stalled result stops intake only while the result register is full and
// not being taken: one more byte is then taken into the input register and
// waits there, whether or not it gives a result, until the result moves.
// Errors (wrong table id, more than MAX_STREAMS entries) end the section;
// bytes are then dropped until the next start. The CRC is not checked.
// ----------------------------------------------------------------------------
module pmt_section_parser
  import pmt_pkg::*;
#(
  parameter int MAX_STREAMS = PMT_MAX_STREAMS
) (
  input  logic      clk,
  input  logic      rst_n,
  pmt_in_if.sink    in_ch,
  pmt_out_if.source out_ch
);

  logic        item_vld;
  pmt_item_t   item;
  logic        adv;
  logic        out_free;
  logic        res_vld;
  pmt_result_t res;

  // advance when a byte waits and the result register can take its result
  assign adv = item_vld && out_free;

  pmt_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .adv      (adv),
    .item_vld (item_vld),
    .item     (item)
  );

  pmt_parse_core #(
    .MAX_STREAMS (MAX_STREAMS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (adv),
    .item    (item),
    .res_vld (res_vld),
    .res     (res)
  );

  pmt_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (adv && res_vld),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_vld |=> out_ch.valid)
    else $error("result word not presented after load");

  a_take_holds: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> item_vld)
    else $error("accepted byte lost in input register");

  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (out_ch.kind == KIND_BAD_TID || out_ch.kind == KIND_TOO_MANY)
      |-> out_ch.last && out_ch.pid == '0 && out_ch.info_length == '0)
    else $error("error result not terminal or carries fields");

  a_hdr_no_type: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.kind == KIND_HEADER |-> out_ch.es_type == '0)
    else $error("header result carries a stream type");

endmodule

>>> sv/pmt_in_stage.sv
// ----------------------------------------------------------------------------
// pmt_in_stage: input register
// Captures one section byte per cycle while empty or as the parser advances; frees on advance.
// ----------------------------------------------------------------------------
module pmt_in_stage
  import pmt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  pmt_in_if.sink        in_ch,
  input  logic          adv,
  output logic          item_vld,
  output pmt_item_t     item
);

  logic      vld_r;
  logic      vld_nxt;
  pmt_item_t item_r;

  assign in_ch.ready = !vld_r || adv;

  always_comb begin
    vld_nxt = vld_r;
    if (in_ch.valid && in_ch.ready) begin
      vld_nxt = 1'b1;
    end else if (adv) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.section_byte  <= in_ch.section_byte;
      item_r.section_start <= in_ch.section_start;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

>>> sv/pmt_parse_core.sv
// ----------------------------------------------------------------------------
// pmt_parse_core: PMT section state machine
// Updates the header, entry and byte-count state for one byte per step and
// forms the result word that the byte causes, if any.
// ----------------------------------------------------------------------------
module pmt_parse_core
  import pmt_pkg::*;
#(
  parameter int MAX_STREAMS = PMT_MAX_STREAMS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  pmt_item_t   item,
  output logic        res_vld,
  output pmt_result_t res
);

  localparam int EntW = $clog2(MAX_STREAMS + 1);
  localparam logic [EntW-1:0] EntMax = EntW'(MAX_STREAMS);

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_SKIP_PI = 5'b00100,
    PH_ENTRY   = 5'b01000,
    PH_SKIP_ES = 5'b10000
  } phase_t;

  phase_t          phase_r,   phase_nxt;
  logic [3:0]      hidx_r,    hidx_nxt;
  logic [11:0]     len_r,     len_nxt;
  logic [13:0]     parsed_r,  parsed_nxt;
  logic [11:0]     skip_r,    skip_nxt;
  logic [2:0]      eidx_r,    eidx_nxt;
  logic [EntW-1:0] ecnt_r,    ecnt_nxt;

  // header and entry fields (payload, no reset)
  logic        syntax_r,  syntax_nxt;
  logic [15:0] prog_r,    prog_nxt;
  logic [4:0]  ver_r,     ver_nxt;
  logic        cn_r,      cn_nxt;
  logic [7:0]  secnum_r,  secnum_nxt;
  logic [7:0]  lastsec_r, lastsec_nxt;
  logic [12:0] pcr_r,     pcr_nxt;
  logic [7:0]  stype_r,   stype_nxt;
  logic [12:0] epid_r,    epid_nxt;
  logic [3:0]  eshi_r,    eshi_nxt;

  logic [7:0]  b;
  logic [11:0] pil;
  logic [11:0] es;
  logic [13:0] cnt_hdr;
  logic [13:0] cnt_ent;
  logic        last_hdr;
  logic        last_ent;

  assign b        = item.section_byte;
  assign pil      = {skip_r[3:0], b};
  assign es       = {eshi_r, b};
  assign cnt_hdr  = PMT_HDR_BASE + {2'b00, pil};
  assign cnt_ent  = parsed_r + PMT_ENTRY_LEN + {2'b00, es};
  assign last_hdr = cnt_hdr >= {2'b00, len_r};
  assign last_ent = cnt_ent >= {2'b00, len_r};

  always_comb begin
    phase_nxt   = phase_r;
    hidx_nxt    = hidx_r;
    len_nxt     = len_r;
    parsed_nxt  = parsed_r;
    skip_nxt    = skip_r;
    eidx_nxt    = eidx_r;
    ecnt_nxt    = ecnt_r;
    syntax_nxt  = syntax_r;
    prog_nxt    = prog_r;
    ver_nxt     = ver_r;
    cn_nxt      = cn_r;
    secnum_nxt  = secnum_r;
    lastsec_nxt = lastsec_r;
    pcr_nxt     = pcr_r;
    stype_nxt   = stype_r;
    epid_nxt    = epid_r;
    eshi_nxt    = eshi_r;
    res_vld     = 1'b0;
    res         = '0;

    if (item.section_start) begin
      // a start byte always opens a new section; a wrong table id ends it at once
      hidx_nxt    = 4'd1;
      len_nxt     = '0;
      parsed_nxt  = '0;
      skip_nxt    = '0;
      eidx_nxt    = '0;
      ecnt_nxt    = '0;
      syntax_nxt  = 1'b0;
      prog_nxt    = '0;
      ver_nxt     = '0;
      cn_nxt      = 1'b0;
      secnum_nxt  = '0;
      lastsec_nxt = '0;
      pcr_nxt     = '0;
      stype_nxt   = '0;
      epid_nxt    = '0;
      eshi_nxt    = '0;
      if (b != PMT_TABLE_ID) begin
        hidx_nxt  = '0;
        phase_nxt = PH_IDLE;
        res_vld   = 1'b1;
        res.kind  = KIND_BAD_TID;
        res.last  = 1'b1;
      end else begin
        phase_nxt = PH_HEADER;
      end
    end else begin
      unique case (phase_r)
        PH_HEADER: begin
          hidx_nxt = hidx_r + 4'd1;
          unique case (hidx_r)
            HB_SYNTAX_LEN_HI: begin
              syntax_nxt = b[7];
              len_nxt    = {b[3:0], 8'h00};
            end
            HB_LEN_LO:   len_nxt       = {len_r[11:8], b};
            HB_PROG_HI:  prog_nxt      = {b, prog_r[7:0]};
            HB_PROG_LO:  prog_nxt      = {prog_r[15:8], b};
            HB_VERSION: begin
              ver_nxt = b[5:1];
              cn_nxt  = b[0];
            end
            HB_SEC_NUM:  secnum_nxt    = b;
            HB_LAST_SEC: lastsec_nxt   = b;
            HB_PCR_HI:   pcr_nxt       = {b[4:0], pcr_r[7:0]};
            HB_PCR_LO:   pcr_nxt       = {pcr_r[12:8], b};
            HB_PIL_HI:   skip_nxt      = {8'h00, b[3:0]};
            default: begin
              // last header byte: report the header
              parsed_nxt = cnt_hdr;
              ecnt_nxt   = '0;
              eidx_nxt   = '0;
              skip_nxt   = pil;
              hidx_nxt   = '0;
              res_vld            = 1'b1;
              res.kind           = KIND_HEADER;
              res.last           = last_hdr;
              res.section_syntax = syntax_r;
              res.sect_len       = len_r;
              res.version        = ver_r;
              res.current_next   = cn_r;
              res.sect_num       = secnum_r;
              res.last_sect_num  = lastsec_r;
              res.prog_num       = prog_r;
              res.pid            = pcr_r;
              res.info_length    = pil;
              if (last_hdr) begin
                phase_nxt = PH_IDLE;
              end else if (pil != '0) begin
                phase_nxt = PH_SKIP_PI;
              end else begin
                phase_nxt = PH_ENTRY;
              end
            end
          endcase
        end
        PH_SKIP_PI, PH_SKIP_ES: begin
          skip_nxt = skip_r - 12'd1;
          if (skip_r == 12'd1) begin
            phase_nxt = PH_ENTRY;
            eidx_nxt  = '0;
          end
        end
        PH_ENTRY: begin
          eidx_nxt = eidx_r + 3'd1;
          unique case (eidx_r)
            EB_STYPE: begin
              if (ecnt_r >= EntMax) begin
                phase_nxt = PH_IDLE;
                res_vld   = 1'b1;
                res.kind  = KIND_TOO_MANY;
                res.last  = 1'b1;
              end else begin
                stype_nxt = b;
              end
            end
            EB_PID_HI: epid_nxt = {b[4:0], epid_r[7:0]};
            EB_PID_LO: epid_nxt = {epid_r[12:8], b};
            EB_ES_HI:  eshi_nxt = b[3:0];
            default: begin
              parsed_nxt = cnt_ent;
              ecnt_nxt   = ecnt_r + EntW'(1);
              eidx_nxt   = '0;
              skip_nxt   = es;
              res_vld            = 1'b1;
              res.kind           = KIND_ENTRY;
              res.last           = last_ent;
              res.section_syntax = syntax_r;
              res.sect_len       = len_r;
              res.version        = ver_r;
              res.current_next   = cn_r;
              res.sect_num       = secnum_r;
              res.last_sect_num  = lastsec_r;
              res.prog_num       = prog_r;
              res.es_type        = stype_r;
              res.pid            = epid_r;
              res.info_length    = es;
              if (last_ent) begin
                phase_nxt = PH_IDLE;
              end else if (es != '0) begin
                phase_nxt = PH_SKIP_ES;
              end else begin
                phase_nxt = PH_ENTRY;
              end
            end
          endcase
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      hidx_r   <= '0;
      len_r    <= '0;
      parsed_r <= '0;
      skip_r   <= '0;
      eidx_r   <= '0;
      ecnt_r   <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      hidx_r   <= hidx_nxt;
      len_r    <= len_nxt;
      parsed_r <= parsed_nxt;
      skip_r   <= skip_nxt;
      eidx_r   <= eidx_nxt;
      ecnt_r   <= ecnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      syntax_r  <= syntax_nxt;
      prog_r    <= prog_nxt;
      ver_r     <= ver_nxt;
      cn_r      <= cn_nxt;
      secnum_r  <= secnum_nxt;
      lastsec_r <= lastsec_nxt;
      pcr_r     <= pcr_nxt;
      stype_r   <= stype_nxt;
      epid_r    <= epid_nxt;
      eshi_r    <= eshi_nxt;
    end
  end

endmodule

>>> sv/pmt_out_stage.sv
// ----------------------------------------------------------------------------
// pmt_out_stage: result register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module pmt_out_stage
  import pmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  pmt_result_t res,
  output logic        free,
  pmt_out_if.source   out_ch
);

  logic        vld_r;
  logic        vld_nxt;
  pmt_result_t res_r;

  assign free = !vld_r || out_ch.ready;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (out_ch.ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = vld_r;
  assign out_ch.kind           = res_r.kind;
  assign out_ch.last           = res_r.last;
  assign out_ch.section_syntax = res_r.section_syntax;
  assign out_ch.sect_len       = res_r.sect_len;
  assign out_ch.version        = res_r.version;
  assign out_ch.current_next   = res_r.current_next;
  assign out_ch.sect_num       = res_r.sect_num;
  assign out_ch.last_sect_num  = res_r.last_sect_num;
  assign out_ch.prog_num       = res_r.prog_num;
  assign out_ch.es_type        = res_r.es_type;
  assign out_ch.pid            = res_r.pid;
  assign out_ch.info_length    = res_r.info_length;

endmodule

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the PMT section parser
// Feeds section words with random gaps and checks every result against a
// byte-level parse kept in the bench. Results are also stalled at random.
// Stimulus covers bad table ids, header field extremes, restarts, the stream
// entry limit, long skips, and a mix of good, broken and noisy sections.
// ----------------------------------------------------------------------------
module tb_top;
  import pmt_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef enum logic [2:0] {
    PS_IDLE, PS_HEADER, PS_SKIP_PI, PS_ENTRY, PS_SKIP_ES
  } parse_state_t;

  logic clk;
  logic rst_n;

  pmt_in_if  in_if ();
  pmt_out_if out_if ();

  pmt_section_parser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source)
  );

  // parse state kept by the bench
  parse_state_t ps;
  logic [3:0]   hdr_pos;
  logic [11:0]  sec_len;
  logic [13:0]  byte_count;
  logic [11:0]  skip_left;
  logic [3:0]   pil_hi;
  logic [2:0]   ent_pos;
  logic [4:0]   n_entries;
  pmt_result_t  hdr_fields;
  logic [7:0]   ent_stype;
  logic [12:0]  ent_pid;
  logic [3:0]   ent_es_hi;

  pmt_result_t want_results[$];

  int errors     = 0;
  int items_sent = 0;
  int cut_left   = -1;
  int stall_left = 0;
  int cycles     = 0;
  bit idle_on    = 1'b1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pmt_result_t make_result(input logic [1:0] kind, input logic last,
                                              input logic [7:0] stype,
                                              input logic [12:0] pid,
                                              input logic [11:0] info);
    pmt_result_t res;
    res = '0;
    if (kind == KIND_HEADER || kind == KIND_ENTRY) begin
      res = hdr_fields;
      res.sect_len = sec_len;
    end
    res.kind        = kind;
    res.last        = last;
    res.es_type     = stype;
    res.pid         = pid;
    res.info_length = info;
    return res;
  endfunction

  task automatic clear_parse();
    hdr_pos    = '0;
    sec_len    = '0;
    byte_count = '0;
    skip_left  = '0;
    pil_hi     = '0;
    ent_pos    = '0;
    n_entries  = '0;
    hdr_fields = '0;
    ent_stype  = '0;
    ent_pid    = '0;
    ent_es_hi  = '0;
  endtask

  // Advance the bench parse by one accepted word; queue any result it gives.
  task automatic parse_byte(input logic [7:0] b, input logic start);
    logic [11:0] len12;
    logic        last;
    len12 = '0;
    last  = 1'b0;
    if (start) begin
      clear_parse();
      if (b != PMT_TABLE_ID) begin
        ps = PS_IDLE;
        want_results.push_back(make_result(KIND_BAD_TID, 1'b1, '0, '0, '0));
      end else begin
        ps      = PS_HEADER;
        hdr_pos = HB_SYNTAX_LEN_HI;
      end
      return;
    end
    case (ps)
      PS_HEADER: begin
        case (hdr_pos)
          HB_SYNTAX_LEN_HI: begin
            hdr_fields.section_syntax = b[7];
            sec_len = {b[3:0], 8'h00};
          end
          HB_LEN_LO:   sec_len[7:0] = b;
          HB_PROG_HI:  hdr_fields.prog_num[15:8] = b;
          HB_PROG_LO:  hdr_fields.prog_num[7:0] = b;
          HB_VERSION: begin
            hdr_fields.version      = b[5:1];
            hdr_fields.current_next = b[0];
          end
          HB_SEC_NUM:  hdr_fields.sect_num = b;
          HB_LAST_SEC: hdr_fields.last_sect_num = b;
          HB_PCR_HI:   hdr_fields.pid[12:8] = b[4:0];
          HB_PCR_LO:   hdr_fields.pid[7:0] = b;
          HB_PIL_HI:   pil_hi = b[3:0];
          default: begin
            len12      = {pil_hi, b};
            byte_count = PMT_HDR_BASE + {2'b00, len12};
            last       = (byte_count >= {2'b00, sec_len});
            want_results.push_back(make_result(KIND_HEADER, last, '0, hdr_fields.pid,
                                               len12));
            n_entries = '0;
            ent_pos   = '0;
            skip_left = len12;
            hdr_pos   = '0;
            if (last) ps = PS_IDLE;
            else if (len12 != 0) ps = PS_SKIP_PI;
            else ps = PS_ENTRY;
            return;
          end
        endcase
        hdr_pos = hdr_pos + 4'd1;
      end
      PS_SKIP_PI, PS_SKIP_ES: begin
        skip_left = skip_left - 12'd1;
        if (skip_left == 0) begin
          ps      = PS_ENTRY;
          ent_pos = '0;
        end
      end
      PS_ENTRY: begin
        case (ent_pos)
          EB_STYPE: begin
            if (n_entries >= PMT_MAX_STREAMS) begin
              ps = PS_IDLE;
              want_results.push_back(make_result(KIND_TOO_MANY, 1'b1, '0, '0, '0));
              return;
            end
            ent_stype = b;
            ent_pid   = '0;
            ent_es_hi = '0;
          end
          EB_PID_HI: ent_pid[12:8] = b[4:0];
          EB_PID_LO: ent_pid[7:0] = b;
          EB_ES_HI:  ent_es_hi = b[3:0];
          default: begin
            len12      = {ent_es_hi, b};
            byte_count = byte_count + PMT_ENTRY_LEN + {2'b00, len12};
            last       = (byte_count >= {2'b00, sec_len});
            n_entries  = n_entries + 5'd1;
            want_results.push_back(make_result(KIND_ENTRY, last, ent_stype, ent_pid, len12));
            ent_pos   = '0;
            skip_left = len12;
            if (last) ps = PS_IDLE;
            else if (len12 != 0) ps = PS_SKIP_ES;
            else ps = PS_ENTRY;
            return;
          end
        endcase
        ent_pos = ent_pos + 3'd1;
      end
      default: ps = PS_IDLE;
    endcase
  endtask

  task automatic report(input string msg);
    if (errors < 40) $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic check_result();
    pmt_result_t want;
    pmt_result_t got;
    if (want_results.size() == 0) begin
      report($sformatf("unexpected result, kind %0d", out_if.kind));
      return;
    end
    want = want_results.pop_front();
    got.kind           = out_if.kind;
    got.last           = out_if.last;
    got.section_syntax = out_if.section_syntax;
    got.sect_len       = out_if.sect_len;
    got.version        = out_if.version;
    got.current_next   = out_if.current_next;
    got.sect_num       = out_if.sect_num;
    got.last_sect_num  = out_if.last_sect_num;
    got.prog_num       = out_if.prog_num;
    got.es_type        = out_if.es_type;
    got.pid            = out_if.pid;
    got.info_length    = out_if.info_length;
    if (got != want) report($sformatf("result got 0x%0h want 0x%0h", got, want));
  endtask

  // result side: check accepted words, stall in short bursts
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) check_result();
    if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 3);
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  // Send one word; once cut_left runs out, drop the rest of the section.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (cut_left == 0) return;
    if (cut_left > 0) cut_left--;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid         <= 1'b1;
    in_if.section_byte  <= b;
    in_if.section_start <= start;
    do @(posedge clk); while (!in_if.ready);
    parse_byte(b, start);
    items_sent++;
  endtask

  task automatic send_rand();
    logic [7:0] r;
    r = 8'($urandom);
    send_byte(r, 1'b0);
  endtask

  // Send a PMT section with n entries; len_force < 0 gives the exact length.
  task automatic send_pmt(input int n, input logic [11:0] pil, input int es_max,
                          input int len_force);
    int          es[$];
    int          total;
    logic [11:0] len;
    logic [11:0] e;
    logic [7:0]  r;
    total = 13 + pil;
    for (int i = 0; i < n; i++) begin
      es.push_back($urandom_range(0, es_max));
      total += 5 + es[i];
    end
    len = (len_force < 0) ? total[11:0] : len_force[11:0];
    send_byte(PMT_TABLE_ID, 1'b1);
    r = 8'($urandom);
    send_byte({r[7:4], len[11:8]}, 1'b0);
    send_byte(len[7:0], 1'b0);
    repeat (7) send_rand();
    r = 8'($urandom);
    send_byte({r[7:4], pil[11:8]}, 1'b0);
    send_byte(pil[7:0], 1'b0);
    foreach (es[i]) begin
      e = 12'(es[i]);
      repeat (3) send_rand();
      r = 8'($urandom);
      send_byte({r[7:4], e[11:8]}, 1'b0);
      send_byte(e[7:0], 1'b0);
      repeat (es[i]) send_rand();
    end
    // CRC
    repeat (4) send_rand();
  endtask

  // drop valid, then hold until every expected result has come
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (want_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_bad_table_id();
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(PMT_TABLE_ID, 1'b0);
    send_byte(8'hFD, 1'b1);
  endtask

  task automatic test_header_bounds();
    send_byte(PMT_TABLE_ID, 1'b1);
    repeat (11) send_byte(8'h00, 1'b0);
    send_byte(PMT_TABLE_ID, 1'b1);
    repeat (11) send_byte(8'hFF, 1'b0);
  endtask

  task automatic test_restart();
    cut_left = 7;
    send_pmt(2, 12'd1, 1, -1);
    cut_left = -1;
    send_pmt(2, 12'd1, 2, -1);
  endtask

  task automatic test_stream_limit();
    send_pmt(PMT_MAX_STREAMS + 1, 12'd0, 0, -1);
    send_pmt(PMT_MAX_STREAMS, 12'd1, 1, -1);
  endtask

  task automatic test_long_skip();
    send_pmt(2, 12'h040 + 12'($urandom_range(0, 63)), 40, 4095);
  endtask

  task automatic test_random_mix();
    int         stop_at;
    int         r;
    int         nb;
    bit         paused;
    logic [7:0] noise;
    stop_at = items_sent + 140;
    paused  = 1'b0;
    while (items_sent < stop_at) begin
      if (items_sent > stop_at - 60) idle_on = 1'b0;
      if (!paused && items_sent > stop_at - 100) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 62) begin
        send_pmt($urandom_range(0, 6), 12'($urandom_range(0, 3)), 3, -1);
      end else if (r < 68) begin
        send_pmt(PMT_MAX_STREAMS + $urandom_range(0, 2), 12'($urandom_range(0, 2)), 1, -1);
      end else if (r < 80) begin
        send_pmt($urandom_range(1, 6), 12'($urandom_range(0, 3)), 3,
                 $urandom_range(0, 80));
      end else if (r < 90) begin
        cut_left = $urandom_range(1, 30);
        send_pmt($urandom_range(1, 4), 12'($urandom_range(0, 3)), 3, -1);
        cut_left = -1;
      end else begin
        nb = $urandom_range(1, 8);
        repeat (nb) begin
          noise = ($urandom_range(0, 3) == 0) ? PMT_TABLE_ID : 8'($urandom);
          send_byte(noise, $urandom_range(0, 3) == 0);
        end
      end
    end
  endtask

  initial begin
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.section_byte  <= '0;
    in_if.section_start <= 1'b0;
    ps = PS_IDLE;
    clear_parse();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_bad_table_id();
    test_header_bounds();
    wait_drained();
    test_restart();
    test_stream_limit();
    wait_drained();
    test_long_skip();
    wait_drained();
    test_random_mix();

    wait_drained();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
sv/pmt_pkg.sv
sv/pmt_if.sv
sv/pmt_in_stage.sv
sv/pmt_parse_core.sv
sv/pmt_out_stage.sv
sv/pmt_section_parser.sv
dv/tb_top.sv
